// ===== design/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants of the graph cycle detector: field widths,
// command and status codes, sequencer states and the item/result structs.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int VTX_W      = 7;
  localparam int EDGES_W    = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [VTX_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // register index as decoded from paddr
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_CLR,
    ST_ROOT,
    ST_POP,
    ST_POP_WAIT,
    ST_HEAD_WAIT,
    ST_SCAN,
    ST_NODE_WAIT,
    ST_VIS_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             cmd;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               has_cycle;
    logic [EDGES_W-1:0] edges_stored;
  } result_t;

endpackage

// ===== design/gcd_in_if.sv =====
// ----------------------------------------------------------------------------
// gcd_in_if
// Input channel of the graph cycle detector: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface gcd_in_if import gcd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [VTX_W-1:0] src_vertex;
  logic [VTX_W-1:0] dst_vertex;

  modport source (output valid, output cmd, output src_vertex, output dst_vertex,
                  input ready);
  modport sink   (input valid, input cmd, input src_vertex, input dst_vertex,
                  output ready);

endinterface

// ===== design/gcd_out_if.sv =====
// ----------------------------------------------------------------------------
// gcd_out_if
// Result channel of the graph cycle detector: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface gcd_out_if import gcd_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               has_cycle;
  logic [EDGES_W-1:0] edges_stored;

  modport source (output valid, output status, output has_cycle, output edges_stored,
                  input ready);
  modport sink   (input valid, input status, input has_cycle, input edges_stored,
                  output ready);

endinterface

// ===== design/gcd_ram.sv =====
// ----------------------------------------------------------------------------
// gcd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gcd_engine.sv =====
// ----------------------------------------------------------------------------
// gcd_engine
// Sequencer and datapath: builds adjacency lists in the node store and runs
// the stack-based depth-first walk, one memory access step per cycle unless a result is held.
// ----------------------------------------------------------------------------
module gcd_engine import gcd_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  logic [VTX_W-1:0] vertex_count,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NODES = 2 * MAX_EDGES;
  localparam int NW    = $clog2(NODES);
  localparam int PW    = $clog2(NODES + 1);
  localparam int EW    = $clog2(MAX_EDGES + 1);
  localparam int SW    = 2 * VW + 1;

  state_t          state_r, state_nxt;
  logic [VW-1:0]   cnt_r, cnt_nxt;
  logic [EW-1:0]   edge_total_r, edge_total_nxt;
  logic [VW:0]     top_r, top_nxt;
  logic [VW:0]     top_dec;
  logic [VW-1:0]   src_r, src_nxt;
  logic [VW-1:0]   dst_r, dst_nxt;
  logic [VW-1:0]   cur_r, cur_nxt;
  logic [VW-1:0]   par_r, par_nxt;
  logic            has_par_r, has_par_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [VW-1:0]   nb_r, nb_nxt;
  status_t         status_r, status_nxt;
  logic            cyc_r, cyc_nxt;

  logic [VTX_W-1:0] eff_lo;
  logic             src_ok, dst_ok;
  logic [NW-1:0]    node_a, node_b;
  logic [PW-1:0]    ptr_a, ptr_b;

  logic            head_we;
  logic [VW-1:0]   head_waddr, head_raddr;
  logic [PW-1:0]   head_wdata, head_rdata;
  logic            node_we;
  logic [NW-1:0]   node_waddr, node_raddr;
  logic [VW+PW-1:0] node_wdata, node_rdata;
  logic            vis_we;
  logic [VW-1:0]   vis_waddr, vis_raddr;
  logic [0:0]      vis_wdata, vis_rdata;
  logic            stk_we;
  logic [VW-1:0]   stk_waddr, stk_raddr;
  logic [SW-1:0]   stk_wdata, stk_rdata;

  // list heads, pointer is node index plus one, zero is null
  gcd_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  // node store: {target, link}
  gcd_ram #(.WIDTH(VW + PW), .DEPTH(NODES)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  gcd_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  // walk stack: {has_parent, parent, vertex}
  gcd_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign eff_lo = (vertex_count == '0) ? 7'd1 : vertex_count;
  assign src_ok = (in_item.src_vertex != '0) && (in_item.src_vertex <= eff_lo) &&
                  (32'(in_item.src_vertex) <= MAX_VERTICES);
  assign dst_ok = (in_item.dst_vertex != '0) && (in_item.dst_vertex <= eff_lo) &&
                  (32'(in_item.dst_vertex) <= MAX_VERTICES);

  assign node_a  = NW'({edge_total_r, 1'b0});
  assign node_b  = NW'({edge_total_r, 1'b1});
  assign ptr_a   = PW'({edge_total_r, 1'b0}) + PW'(1);
  assign ptr_b   = PW'({edge_total_r, 1'b0}) + PW'(2);
  assign top_dec = top_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      edge_total_r <= '0;
      top_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      edge_total_r <= edge_total_nxt;
      top_r        <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    cur_r     <= cur_nxt;
    par_r     <= par_nxt;
    has_par_r <= has_par_nxt;
    p_r       <= p_nxt;
    nb_r      <= nb_nxt;
    status_r  <= status_nxt;
    cyc_r     <= cyc_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    edge_total_nxt = edge_total_r;
    top_nxt        = top_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    cur_nxt        = cur_r;
    par_nxt        = par_r;
    has_par_nxt    = has_par_r;
    p_nxt          = p_r;
    nb_nxt         = nb_r;
    status_nxt     = status_r;
    cyc_nxt        = cyc_r;

    in_ready   = 1'b0;
    res_valid  = 1'b0;

    head_we    = 1'b0;
    head_waddr = cnt_r;
    head_wdata = '0;
    head_raddr = src_r;
    node_we    = 1'b0;
    node_waddr = node_a;
    node_wdata = {dst_r, head_rdata};
    node_raddr = NW'(p_r - PW'(1));
    vis_we     = 1'b0;
    vis_waddr  = cnt_r;
    vis_wdata  = 1'b0;
    vis_raddr  = node_rdata[VW+PW-1:PW];
    stk_we     = 1'b0;
    stk_waddr  = top_r[VW-1:0];
    stk_wdata  = {1'b1, cur_r, nb_r};
    stk_raddr  = top_dec[VW-1:0];

    case (state_r)
      ST_INIT: begin
        // clearing pass over the list heads
        head_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VW'(MAX_VERTICES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cyc_nxt     = 1'b0;
        status_nxt  = STATUS_OK;
        src_nxt     = VW'(in_item.src_vertex - 7'd1);
        dst_nxt     = VW'(in_item.dst_vertex - 7'd1);
        if (in_valid) begin
          if (in_item.cmd == CMD_CHECK) begin
            cnt_nxt   = '0;
            state_nxt = ST_CLR;
          end else if (!src_ok || !dst_ok) begin
            status_nxt = STATUS_RANGE;
            state_nxt  = ST_DONE;
          end else if (edge_total_r == EW'(MAX_EDGES)) begin
            status_nxt = STATUS_FULL;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_ADD_RD_A;
          end
        end
      end
      ST_ADD_RD_A: begin
        head_raddr = src_r;
        state_nxt  = ST_ADD_WR_A;
      end
      ST_ADD_WR_A: begin
        node_we    = 1'b1;
        node_waddr = node_a;
        node_wdata = {dst_r, head_rdata};
        head_we    = 1'b1;
        head_waddr = src_r;
        head_wdata = ptr_a;
        state_nxt  = ST_ADD_RD_B;
      end
      ST_ADD_RD_B: begin
        // read after the first head update so a self-loop chains correctly
        head_raddr = dst_r;
        state_nxt  = ST_ADD_WR_B;
      end
      ST_ADD_WR_B: begin
        node_we        = 1'b1;
        node_waddr     = node_b;
        node_wdata     = {src_r, head_rdata};
        head_we        = 1'b1;
        head_waddr     = dst_r;
        head_wdata     = ptr_b;
        edge_total_nxt = edge_total_r + 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = cnt_r;
        vis_wdata = 1'b0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == VW'(MAX_VERTICES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        vis_we    = 1'b1;
        vis_waddr = '0;
        vis_wdata = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
        top_nxt   = (VW+1)'(1);
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (top_r == '0) begin
          cyc_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          stk_raddr = top_dec[VW-1:0];
          top_nxt   = top_dec;
          state_nxt = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cur_nxt     = stk_rdata[VW-1:0];
        par_nxt     = stk_rdata[2*VW-1:VW];
        has_par_nxt = stk_rdata[2*VW];
        head_raddr  = stk_rdata[VW-1:0];
        state_nxt   = ST_HEAD_WAIT;
      end
      ST_HEAD_WAIT: begin
        p_nxt     = head_rdata;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (p_r == '0) begin
          state_nxt = ST_POP;
        end else begin
          node_raddr = NW'(p_r - PW'(1));
          state_nxt  = ST_NODE_WAIT;
        end
      end
      ST_NODE_WAIT: begin
        nb_nxt    = node_rdata[VW+PW-1:PW];
        p_nxt     = node_rdata[PW-1:0];
        vis_raddr = node_rdata[VW+PW-1:PW];
        state_nxt = ST_VIS_WAIT;
      end
      ST_VIS_WAIT: begin
        if (vis_rdata[0] == 1'b0) begin
          if (top_r < (VW+1)'(MAX_VERTICES)) begin
            stk_we    = 1'b1;
            stk_waddr = top_r[VW-1:0];
            stk_wdata = {1'b1, cur_r, nb_r};
            top_nxt   = top_r + 1'b1;
          end
          vis_we    = 1'b1;
          vis_waddr = nb_r;
          vis_wdata = 1'b1;
          state_nxt = ST_SCAN;
        end else if (!has_par_r || (nb_r != par_r)) begin
          cyc_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.status       = status_r;
  assign res.has_cycle    = cyc_r;
  assign res.edges_stored = EDGES_W'(edge_total_r);

`ifndef NO_ASSERTIONS
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= (VW+1)'(MAX_VERTICES))
    else $error("walk stack depth above vertex count");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= EW'(MAX_EDGES))
    else $error("edge total above store size");

  a_edge_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (edge_total_r != $past(edge_total_r)))
      |-> (edge_total_r == $past(edge_total_r) + 1'b1))
    else $error("edge total moved by more than one");

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && res_valid))
    else $error("engine ready while a result is pending");

  a_cycle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.has_cycle) |-> (res.status == STATUS_OK))
    else $error("cycle flag with error status");
`endif

endmodule

// ===== design/graph_cycle_detector_top.sv =====
// ----------------------------------------------------------------------------
// graph_cycle_detector_top
// Undirected graph cycle detector with APB configuration port.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one item per beat. cmd = add puts edge
// (src_vertex, dst_vertex), 1-based, into the node store; cmd = check runs a
// depth-first walk from vertex 1 and reports has_cycle. Every item gives
// exactly one beat on out_ch with status, has_cycle and edges_stored.
// The APB port holds vertex_count at addresses 0 to 3 (paddr[2] clear; writes elsewhere ignored).
// Timing: one item at a time, in_ch.ready is high only while the sequencer
// is idle. An add links a new node into the list of each endpoint in turn;
// a rejected add goes straight to its result. A check clears the visited
// marks, pushes vertex 1, then pops vertices and scans their adjacency
// nodes; a walk that meets a cycle stops at that node. Each walk step is
// an access to the separate head, node, visited and stack memories.
// Reset: rst_n is synchronous; after it the list heads are cleared in a
// pass during which no item is accepted.
// Stall: a result sits in the output register until out_ch.ready; a second
// finished result waits in the sequencer, which then takes no new item.
// ----------------------------------------------------------------------------
module graph_cycle_detector_top import gcd_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gcd_in_if.sink                in_ch,
  gcd_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [VTX_W-1:0] vertex_count_r, vertex_count_nxt;
  logic             reg_hit;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;
  item_t            in_item;
  logic             res_valid, res_ready;
  result_t          res;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_VERTEX_COUNT);
  assign prdata  = reg_hit ? CFG_DATA_W'(vertex_count_r) : '0;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      vertex_count_nxt = pwdata[VTX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
    end else begin
      vertex_count_r <= vertex_count_nxt;
    end
  end

  assign in_item.cmd        = in_ch.cmd;
  assign in_item.src_vertex = in_ch.src_vertex;
  assign in_item.dst_vertex = in_ch.dst_vertex;

  gcd_engine #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_item),
    .vertex_count(vertex_count_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register, refilled in the same cycle the old beat leaves
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.has_cycle    = out_res_r.has_cycle;
  assign out_ch.edges_stored = out_res_r.edges_stored;

endmodule

// ===== verif/tb_graph_cycle_detector_top.sv =====
// ----------------------------------------------------------------------------
// tb_graph_cycle_detector_top
// Self-checking bench for the graph cycle detector. A scoreboard class keeps
// its own copy of the adjacency store and the vertex count register. It
// predicts status, cycle flag and edge count for every accepted item and
// compares them with each result beat. Stimulus has a short directed part,
// then a forest that grows from vertex 1 with random checks, then phases that
// close cycles and fill the edge store under several vertex counts. Both
// channels idle at random, and the result side holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
package gcd_tb_pkg;
  import gcd_pkg::*;

  localparam int VTX_CAP    = 64;
  localparam int EDGE_CAP   = 256;
  localparam int NODE_SLOTS = 2 * EDGE_CAP;
  localparam int NO_PARENT  = -1;

  class cycle_scoreboard;
    int node_target[NODE_SLOTS];
    int node_link[NODE_SLOTS];
    int list_head[VTX_CAP];
    int edge_total;
    logic [VTX_W-1:0] vertex_count;
    result_t expected_results[$];
    int results_checked;
    int mismatches;

    function new();
      foreach (list_head[i]) list_head[i] = 0;
      edge_total = 0;
      vertex_count = VCOUNT_RESET;
      results_checked = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr[CFG_ADDR_W-1:2] == REG_VERTEX_COUNT) vertex_count = data[VTX_W-1:0];
    endfunction

    // new node goes to the front of the owner's list; links hold index plus one
    function void link_node(int node, int owner, int target);
      node_target[node] = target;
      node_link[node] = list_head[owner];
      list_head[owner] = node + 1;
    endfunction

    function bit walk_finds_cycle();
      bit seen[VTX_CAP];
      int stack_vtx[VTX_CAP];
      int stack_par[VTX_CAP];
      int depth;
      int cur;
      int par;
      int p;
      int nb;
      foreach (seen[i]) seen[i] = 1'b0;
      stack_vtx[0] = 0;
      stack_par[0] = NO_PARENT;
      seen[0] = 1'b1;
      depth = 1;
      while (depth > 0) begin
        depth--;
        cur = stack_vtx[depth];
        par = stack_par[depth];
        p = list_head[cur];
        while (p != 0) begin
          nb = node_target[p-1];
          if (!seen[nb]) begin
            if (depth < VTX_CAP) begin
              stack_vtx[depth] = nb;
              stack_par[depth] = cur;
              depth++;
            end
            seen[nb] = 1'b1;
          end else if (nb != par) begin
            return 1'b1;
          end
          p = node_link[p-1];
        end
      end
      return 1'b0;
    endfunction

    function void note_item(logic cmd, logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst);
      result_t r;
      int lim;
      r.status = STATUS_OK;
      r.has_cycle = 1'b0;
      if (cmd == CMD_CHECK) begin
        r.has_cycle = walk_finds_cycle();
      end else begin
        lim = (vertex_count < 1) ? 1 : (vertex_count > VTX_CAP) ? VTX_CAP : int'(vertex_count);
        if (src < 1 || src > lim || dst < 1 || dst > lim) begin
          r.status = STATUS_RANGE;
        end else if (edge_total >= EDGE_CAP) begin
          r.status = STATUS_FULL;
        end else begin
          link_node(2 * edge_total, int'(src) - 1, int'(dst) - 1);
          link_node(2 * edge_total + 1, int'(dst) - 1, int'(src) - 1);
          edge_total++;
        end
      end
      r.edges_stored = EDGES_W'(edge_total);
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch %0d: %s", mismatches, what);
    endtask

    task check_result(logic [1:0] status, logic has_cycle,
                      logic [EDGES_W-1:0] edges_stored);
      result_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_checked));
        return;
      end
      want = expected_results.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                  results_checked, status, want.status));
      if (has_cycle !== want.has_cycle)
        report_mismatch($sformatf("beat %0d has_cycle %0d, want %0d",
                                  results_checked, has_cycle, want.has_cycle));
      if (edges_stored !== want.edges_stored)
        report_mismatch($sformatf("beat %0d edges_stored %0d, want %0d",
                                  results_checked, edges_stored, want.edges_stored));
    endtask
  endclass
endpackage

module tb_graph_cycle_detector_top;
  import gcd_pkg::*;
  import gcd_tb_pkg::*;

  localparam int STALL_LIMIT = 10000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 60;
  localparam int DRAIN_TAIL  = 20;

  localparam logic [CFG_ADDR_W-1:0] ADDR_VCOUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE  = 3'd4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  gcd_in_if  in_if ();
  gcd_out_if out_if ();

  cycle_scoreboard sb = new();

  bit quiet;
  bit src_gappy;
  int idle_cycles = 0;

  graph_cycle_detector_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor; also counts cycles in which nothing moves
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1)
      sb.note_item(in_if.cmd, in_if.src_vertex, in_if.dst_vertex);
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.status, out_if.has_cycle, out_if.edges_stored);
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL graph_cycle_detector_top");
    $finish;
  end

  // result side: random stall bursts, one long hold-off so the block backs up
  initial begin
    bit gappy;
    bit held;
    gappy = 1'b1;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.results_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_if.ready = 1'b1;
      if ($urandom_range(0, 40) == 0) gappy = !gappy;
    end
  end

  function automatic logic [VTX_W-1:0] vtx(int lo, int hi);
    return VTX_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [VTX_W-1:0] bad_vtx();
    return $urandom_range(0, 1) ? '0 : vtx(65, 127);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat,
  // with valid still high so back-to-back beats need no toggle
  task automatic push_beat(logic cmd, logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst);
    if (!quiet && src_gappy && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    if ($urandom_range(0, 30) == 0) src_gappy = !src_gappy;
    in_if.valid = 1'b1;
    in_if.cmd = cmd;
    in_if.src_vertex = src;
    in_if.dst_vertex = dst;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (sb.expected_results.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    settle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(addr, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int k;
    int pick;
    int idx;
    int v;
    int u;
    int extra;
    int tree_q[$];
    int spare_q[$];

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_ADD;
    in_if.src_vertex = '0;
    in_if.dst_vertex = '0;
    quiet = 1'b0;
    src_gappy = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // empty graph, out-of-range endpoints, a short path from vertex 1
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    push_beat(CMD_CHECK, 7'd127, 7'd127);
    push_beat(CMD_ADD, 7'd0, 7'd5);
    push_beat(CMD_ADD, 7'd5, 7'd0);
    push_beat(CMD_ADD, 7'd65, 7'd1);
    push_beat(CMD_ADD, 7'd1, 7'd127);
    push_beat(CMD_ADD, 7'd1, 7'd2);
    push_beat(CMD_ADD, 7'd3, 7'd2);
    // self-loop and doubled edge away from vertex 1 stay unseen
    push_beat(CMD_ADD, 7'd64, 7'd64);
    push_beat(CMD_ADD, 7'd40, 7'd41);
    push_beat(CMD_ADD, 7'd41, 7'd40);
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    write_reg(ADDR_SPARE, 32'd2);
    push_beat(CMD_ADD, 7'd50, 7'd51);
    // upper data bits are dropped: this sets a count of one
    write_reg(ADDR_VCOUNT, 32'hFFFF_FF81);
    push_beat(CMD_ADD, 7'd1, 7'd2);
    push_beat(CMD_ADD, 7'd2, 7'd1);
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    write_reg(ADDR_VCOUNT, 32'd0);
    push_beat(CMD_ADD, 7'd2, 7'd2);
    push_beat(CMD_ADD, 7'd1, 7'd0);
    write_reg(ADDR_VCOUNT, 32'd127);
    push_beat(CMD_ADD, 7'd64, 7'd63);
    push_beat(CMD_ADD, 7'd65, 7'd65);
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    write_reg(ADDR_VCOUNT, 32'd64);

    // grow a tree over 1..32 while 33..64 get arbitrary edges, so no cycle
    // is reachable from vertex 1 yet
    tree_q = '{1, 2, 3};
    for (k = 4; k <= 32; k++) spare_q.push_back(k);
    for (k = 0; k < 180; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && spare_q.size() > 0) begin
        idx = $urandom_range(0, spare_q.size() - 1);
        v = spare_q[idx];
        spare_q.delete(idx);
        u = tree_q[$urandom_range(0, tree_q.size() - 1)];
        tree_q.push_back(v);
        if ($urandom_range(0, 1)) push_beat(CMD_ADD, VTX_W'(u), VTX_W'(v));
        else push_beat(CMD_ADD, VTX_W'(v), VTX_W'(u));
      end else if (pick < 70) begin
        push_beat(CMD_ADD, vtx(33, 64), vtx(33, 64));
      end else if (pick < 85) begin
        push_beat(CMD_CHECK, vtx(0, 127), vtx(0, 127));
      end else if ($urandom_range(0, 1)) begin
        push_beat(CMD_ADD, bad_vtx(), vtx(0, 127));
      end else begin
        push_beat(CMD_ADD, vtx(0, 127), bad_vtx());
      end
    end

    // doubled tree edge at vertex 1, then free edges over a narrower range
    write_reg(ADDR_VCOUNT, 32'd20);
    push_beat(CMD_ADD, 7'd2, 7'd1);
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    for (k = 0; k < 60; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) push_beat(CMD_ADD, vtx(1, 20), vtx(1, 20));
      else if (pick < 70) push_beat(CMD_CHECK, vtx(0, 127), vtx(0, 127));
      else push_beat(CMD_ADD, vtx(0, 127), vtx(0, 127));
    end

    // count above the vertex limit; fill the edge store and go past it
    write_reg(ADDR_VCOUNT, 32'd127);
    push_beat(CMD_ADD, 7'd1, 7'd1);
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    extra = 0;
    while (extra < 15) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        if ($urandom_range(0, 9) == 0) push_beat(CMD_ADD, vtx(0, 127), vtx(0, 127));
        else push_beat(CMD_ADD, vtx(1, 64), vtx(1, 64));
      end else begin
        push_beat(CMD_CHECK, vtx(0, 127), vtx(0, 127));
      end
      if (sb.edge_total >= EDGE_CAP) extra++;
    end

    // range test wins over the full test; no idling from here on
    write_reg(ADDR_VCOUNT, 32'd0);
    quiet = 1'b1;
    push_beat(CMD_ADD, 7'd1, 7'd1);
    push_beat(CMD_ADD, 7'd1, 7'd2);
    push_beat(CMD_ADD, 7'd0, 7'd1);
    push_beat(CMD_CHECK, 7'd0, 7'd0);
    for (k = 0; k < 15; k++) push_beat(logic'($urandom_range(0, 1)), vtx(0, 127), vtx(0, 127));
    write_reg(ADDR_VCOUNT, 32'd64);
    push_beat(CMD_ADD, 7'd5, 7'd6);
    push_beat(CMD_CHECK, 7'd0, 7'd0);

    settle();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS graph_cycle_detector_top");
    end else begin
      $display("FAIL graph_cycle_detector_top");
    end
    $finish;
  end

endmodule
